FILE: rtl/ceia_pkg.sv
// ----------------------------------------------------------------------------
// ceia_pkg
// shared widths, codes and the sequencer state type of the crank edge
// interval averager
// ----------------------------------------------------------------------------
package ceia_pkg;

   localparam int TIME_W        = 48;
   localparam int CFG_W         = 24;
   localparam int RES_W         = 32;
   localparam int CNT_W         = $clog2(TIME_W);
   localparam int CFG_IW        = $clog2(CFG_W);
   localparam int DEPTH_DEFAULT = 8;
   localparam int CSR_IDX_W     = 1;

   localparam logic [CFG_W-1:0] TIMEOUT_RESET = CFG_W'(3000000);

   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = CSR_IDX_W'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE_CALC,
      S_EDGE_DECIDE,
      S_PUSH_SYN,
      S_PUSH_TIME,
      S_Q_RD_NEW,
      S_Q_LD_NEW,
      S_Q_AGE,
      S_Q_CHECK,
      S_Q_RD_OLD,
      S_Q_LD_OLD,
      S_Q_SPAN,
      S_Q_DIV_GO,
      S_Q_DIV,
      S_Q_DONE
   } state_type;

endpackage

FILE: rtl/ceia_ram.sv
// ----------------------------------------------------------------------------
// ceia_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ceia_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/ceia_serial_div.sv
// ----------------------------------------------------------------------------
// ceia_serial_div
// restoring divider, one quotient bit per cycle, keeps the low quotient bits
// ----------------------------------------------------------------------------
module ceia_serial_div import ceia_pkg::*; #(
   parameter int DIV_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic              done,
   output logic [RES_W-1:0]  quotient
);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [TIME_W-1:0] dvd_ff;
   logic [DIV_W-1:0]  dsr_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [RES_W-1:0]  quo_ff;
   logic [DIV_W:0]    trial;
   logic              fits;
   logic [DIV_W:0]    diff;

   assign trial = {rem_ff, dvd_ff[TIME_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TIME_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[TIME_W-2:0], 1'b0};
         rem_ff <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_ff <= {quo_ff[RES_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/crank_edge_interval_averager_core.sv
// ----------------------------------------------------------------------------
// crank_edge_interval_averager_core
// crank period from rising edge stamps, bit-serial datapath
// ----------------------------------------------------------------------------
// req channel: req_tuser selects the word kind (0 edge, 1 query), req_tdata
// carries the 48-bit time in us. an edge passes the lockout test only when
// its time is above the deadline; it then lands in a ring of DEPTH stamps.
// a query returns one rsp word with the average interval (0 when unknown).
// csr port: csr_addr 0 lockout period, 1 timeout; write only while idle.
// timing: all time arithmetic runs one bit per cycle over 48 bits. an edge
// takes a serial lockout pass, a query a serial age check, span subtract
// and restoring divide; the span and divide are skipped when the age check
// clears the history or only one stamp is held, all three when none is held.
// one word is in flight at a time; req_tready is high in idle only.
// the rsp register lets a new req word in while a result still waits; a
// stalled rsp_tready holds a finished query in its last step.
// reset: synchronous, clears the history, the deadline and the csr values
// (lockout 0, timeout 3000000); the stamp ram needs no clearing.
// ----------------------------------------------------------------------------
module crank_edge_interval_averager_core import ceia_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TIME_W-1:0]    req_tdata,   // time_us
   input  logic                 req_tuser,   // op
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RES_W-1:0]     rsp_tdata,   // interval_us
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   function automatic logic [PW-1:0] slot_after(input logic [PW-1:0] base,
                                                input logic [CW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(base) + SW'(off);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[PW-1:0];
   endfunction

   function automatic logic borrow(input logic a, input logic b, input logic bin);
      return (~a & b) | (~(a ^ b) & bin);
   endfunction

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  bit_cnt_ff;
   logic              last_bit;
   logic [CFG_W-1:0]  lockout_ff;
   logic [CFG_W-1:0]  timeout_ff;
   logic [TIME_W-1:0] nat_ff;
   logic [CW-1:0]     count_ff;
   logic [PW-1:0]     oldest_ff;
   logic              chain0_ff, chain1_ff, chain2_ff;
   logic [TIME_W-1:0] time_ff;
   logic [TIME_W-1:0] new_ff;
   logic [TIME_W-1:0] aux_ff;
   logic [TIME_W-1:0] acc_ff;
   logic [RES_W-1:0]  res_ff;
   logic              rsp_tvalid_ff;
   logic [RES_W-1:0]  rsp_tdata_ff;

   logic              req_acc;
   logic              rsp_free;
   logic              full;
   logic              serial;
   logic              tb, nb, wb, ob, lb, kb;
   logic              age_bit;
   logic              clear_hist;
   logic              ram_we, ram_re;
   logic [PW-1:0]     ram_waddr, ram_raddr;
   logic [TIME_W-1:0] ram_wdata, ram_rdata;
   logic              div_start, div_done;
   logic [RES_W-1:0]  div_quo;

   assign req_acc    = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_tvalid_ff | rsp_tready;
   assign full       = count_ff == CW'(DEPTH);
   assign last_bit   = bit_cnt_ff == CNT_W'(TIME_W - 1);
   assign serial     = (state_ff == S_EDGE_CALC) || (state_ff == S_Q_AGE) ||
                       (state_ff == S_Q_SPAN);
   assign clear_hist = ~chain1_ff;

   assign tb = time_ff[0];
   assign nb = nat_ff[0];
   assign wb = new_ff[0];
   assign ob = aux_ff[0];
   assign lb = (bit_cnt_ff < CNT_W'(CFG_W)) ? lockout_ff[bit_cnt_ff[CFG_IW-1:0]] : 1'b0;
   assign kb = (bit_cnt_ff < CNT_W'(CFG_W)) ? timeout_ff[bit_cnt_ff[CFG_IW-1:0]] : 1'b0;
   assign age_bit = tb ^ wb ^ chain0_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tuser == OP_EDGE) begin
                  state_in = S_EDGE_CALC;
               end else if (count_ff == '0) begin
                  state_in = S_Q_DONE;
               end else begin
                  state_in = S_Q_RD_NEW;
               end
            end
         end
         S_EDGE_CALC: begin
            if (last_bit) begin
               state_in = S_EDGE_DECIDE;
            end
         end
         S_EDGE_DECIDE: begin
            if (!chain0_ff) begin
               state_in = S_IDLE;
            end else if (count_ff == '0) begin
               state_in = S_PUSH_SYN;
            end else begin
               state_in = S_PUSH_TIME;
            end
         end
         S_PUSH_SYN:  state_in = S_PUSH_TIME;
         S_PUSH_TIME: state_in = S_IDLE;
         S_Q_RD_NEW:  state_in = S_Q_LD_NEW;
         S_Q_LD_NEW:  state_in = S_Q_AGE;
         S_Q_AGE: begin
            if (last_bit) begin
               state_in = S_Q_CHECK;
            end
         end
         S_Q_CHECK: begin
            if (!clear_hist && count_ff > CW'(1)) begin
               state_in = S_Q_RD_OLD;
            end else begin
               state_in = S_Q_DONE;
            end
         end
         S_Q_RD_OLD: state_in = S_Q_LD_OLD;
         S_Q_LD_OLD: state_in = S_Q_SPAN;
         S_Q_SPAN: begin
            if (last_bit) begin
               state_in = S_Q_DIV_GO;
            end
         end
         S_Q_DIV_GO: state_in = S_Q_DIV;
         S_Q_DIV: begin
            if (div_done) begin
               state_in = S_Q_DONE;
            end
         end
         S_Q_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_raddr  = oldest_ff;
      div_start  = 1'b0;
      unique case (state_ff)
         S_IDLE:      req_tready = 1'b1;
         S_PUSH_SYN:  ram_we     = 1'b1;
         S_PUSH_TIME: ram_we     = 1'b1;
         S_Q_RD_NEW: begin
            ram_re    = 1'b1;
            ram_raddr = slot_after(oldest_ff, count_ff - CW'(1));
         end
         S_Q_RD_OLD:  ram_re     = 1'b1;
         S_Q_DIV_GO:  div_start  = 1'b1;
         default: ;
      endcase
   end

   assign ram_waddr = full ? oldest_ff : slot_after(oldest_ff, count_ff);
   assign ram_wdata = (state_ff == S_PUSH_SYN) ? aux_ff : time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bit_cnt_ff    <= '0;
         lockout_ff    <= '0;
         timeout_ff    <= TIMEOUT_RESET;
         nat_ff        <= '0;
         count_ff      <= '0;
         oldest_ff     <= '0;
         chain0_ff     <= 1'b0;
         chain1_ff     <= 1'b0;
         chain2_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= (serial && !last_bit) ? bit_cnt_ff + 1'b1 : '0;

         if (csr_we) begin
            unique case (csr_addr)
               CSR_LOCKOUT: lockout_ff <= csr_wdata;
               CSR_TIMEOUT: timeout_ff <= csr_wdata;
               default: ;
            endcase
         end

         unique case (state_ff)
            S_EDGE_CALC: begin
               chain0_ff <= borrow(nb, tb, chain0_ff);
               chain1_ff <= (tb & lb) | (tb & chain1_ff) | (lb & chain1_ff);
               chain2_ff <= borrow(tb, kb, chain2_ff);
               nat_ff    <= {nb, nat_ff[TIME_W-1:1]};
            end
            S_Q_AGE: begin
               chain0_ff <= borrow(tb, wb, chain0_ff);
               chain1_ff <= borrow(age_bit, kb, chain1_ff);
            end
            S_Q_SPAN: begin
               chain0_ff <= borrow(wb, ob, chain0_ff);
            end
            S_Q_CHECK: begin
               chain0_ff <= 1'b0;
               chain1_ff <= 1'b0;
               if (clear_hist) begin
                  count_ff  <= '0;
                  oldest_ff <= '0;
               end
            end
            S_EDGE_DECIDE: begin
               chain0_ff <= 1'b0;
               chain1_ff <= 1'b0;
               chain2_ff <= 1'b0;
               if (chain0_ff) begin
                  nat_ff <= acc_ff;
               end
            end
            S_PUSH_SYN, S_PUSH_TIME: begin
               if (!full) begin
                  count_ff <= count_ff + CW'(1);
               end else begin
                  oldest_ff <= slot_after(oldest_ff, CW'(1));
               end
            end
            default: begin
               chain0_ff <= 1'b0;
               chain1_ff <= 1'b0;
               chain2_ff <= 1'b0;
            end
         endcase

         if (state_ff == S_Q_DONE && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               time_ff <= req_tdata;
               res_ff  <= '0;
            end
         end
         S_EDGE_CALC: begin
            time_ff <= {tb, time_ff[TIME_W-1:1]};
            acc_ff  <= {tb ^ lb ^ chain1_ff, acc_ff[TIME_W-1:1]};
            aux_ff  <= {tb ^ kb ^ chain2_ff, aux_ff[TIME_W-1:1]};
         end
         S_Q_LD_NEW: new_ff <= ram_rdata;
         S_Q_AGE: begin
            time_ff <= {tb, time_ff[TIME_W-1:1]};
            new_ff  <= {wb, new_ff[TIME_W-1:1]};
         end
         S_Q_LD_OLD: aux_ff <= ram_rdata;
         S_Q_SPAN: begin
            new_ff <= {wb, new_ff[TIME_W-1:1]};
            aux_ff <= {ob, aux_ff[TIME_W-1:1]};
            acc_ff <= {wb ^ ob ^ chain0_ff, acc_ff[TIME_W-1:1]};
         end
         S_Q_DIV: begin
            if (div_done) begin
               res_ff <= div_quo;
            end
         end
         S_Q_DONE: begin
            if (rsp_free) begin
               rsp_tdata_ff <= res_ff;
            end
         end
         default: ;
      endcase
   end

   ceia_ram #(
      .WIDTH (TIME_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ceia_serial_div #(
      .DIV_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (count_ff - CW'(1)),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("stamp count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> (count_ff == $past(count_ff) + CW'(1)) ||
                                      (count_ff == '0))
      else $error("stamp count moved by more than one");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_Q_DIV)
      else $error("divider finished outside the divide step");

   a_push_edge: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> $past(state_ff) == S_EDGE_DECIDE || $past(state_ff) == S_PUSH_SYN)
      else $error("stamp written without an accepted edge");

endmodule

FILE: verif/tb_crank_edge_interval_averager_core.sv
// ----------------------------------------------------------------------------
// tb_crank_edge_interval_averager_core
// self-checking bench for the crank edge interval averager. a behavioral
// model of the stamp history, lockout deadline and timeout clearing runs
// beside the core and predicts the interval word of every query. directed
// words cover the reset values, lockout edges, ring overflow, the timeout
// boundary and time wrap; random crank bursts with interleaved queries,
// bounces and noise follow under several csr settings and stall patterns.
// ----------------------------------------------------------------------------
module tb_crank_edge_interval_averager_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ceia_pkg::*;

   localparam int                HIST_DEPTH    = DEPTH_DEFAULT;
   localparam int                SETTLE_CYCLES = 64;
   localparam logic [TIME_W-1:0] TIME_MAX      = '1;
   localparam logic [TIME_W-1:0] NEAR_TOP      = 48'h0100_0000_0000;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [TIME_W-1:0]    req_tdata  = '0;
   logic                 req_tuser  = OP_EDGE;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RES_W-1:0]     rsp_tdata;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr   = CSR_LOCKOUT;
   logic [CFG_W-1:0]     csr_wdata  = '0;

   // model state
   logic [TIME_W-1:0] hist_ring [HIST_DEPTH];
   int                hist_oldest   = 0;
   int                hist_count    = 0;
   logic [TIME_W-1:0] edge_deadline = '0;
   logic [CFG_W-1:0]  lockout_cfg   = '0;
   logic [CFG_W-1:0]  timeout_cfg   = TIMEOUT_RESET;
   logic [RES_W-1:0]  interval_q [$];
   logic [RES_W-1:0]  interval_expected;

   logic [TIME_W-1:0] crank_now   = '0;
   int                tx_idle_pct = 9;
   int                rx_idle_pct = 60;
   int                error_count = 0;
   int                word_total  = 0;

   crank_edge_interval_averager_core #(
      .DEPTH(HIST_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [TIME_W-1:0] hist_newest();
      return hist_ring[(hist_oldest + hist_count - 1) % HIST_DEPTH];
   endfunction

   function automatic void hist_push(input logic [TIME_W-1:0] stamp);
      if (hist_count < HIST_DEPTH) begin
         hist_ring[(hist_oldest + hist_count) % HIST_DEPTH] = stamp;
         hist_count++;
      end else begin
         hist_ring[hist_oldest] = stamp;
         hist_oldest = (hist_oldest + 1) % HIST_DEPTH;
      end
   endfunction

   // returns 1 when the word has an effect (query, or edge past the lockout)
   function automatic bit apply_word(input logic op, input logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] quo;
      if (op == OP_EDGE) begin
         if (t <= edge_deadline) return 1'b0;
         edge_deadline = t + TIME_W'(lockout_cfg);
         if (hist_count == 0) hist_push(t - TIME_W'(timeout_cfg));
         hist_push(t);
         return 1'b1;
      end
      if (hist_count > 0) begin
         age = t - hist_newest();
         if (age >= TIME_W'(timeout_cfg)) begin
            hist_count  = 0;
            hist_oldest = 0;
         end
      end
      quo = '0;
      if (hist_count > 1) begin
         span = hist_newest() - hist_ring[hist_oldest];
         quo  = span / TIME_W'(hist_count - 1);
      end
      interval_q.push_back(quo[RES_W-1:0]);
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [RES_W-1:0] got,
                                  input logic [RES_W-1:0] want);
      if (error_count < 50)
         $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_word(input logic op, input logic [TIME_W-1:0] t);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      void'(apply_word(op, t));
      word_total++;
   endtask

   // hold the sender until every interval word is back and the core is quiet
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (interval_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LOCKOUT) lockout_cfg = value;
      else timeout_cfg = value;
   endtask

   task automatic crank_burst();
      int unsigned       n_edges;
      int unsigned       period;
      int unsigned       lag;
      int                k;
      logic [TIME_W-1:0] t;
      n_edges = $urandom_range(2, 12);
      if ($urandom_range(99) < 15) period = lockout_cfg + timeout_cfg + $urandom_range(0, 1000);
      else period = lockout_cfg + 1 + $urandom_range(0, timeout_cfg / 2);
      if (lockout_cfg != 0 && $urandom_range(99) < 8) begin
         crank_now = TIME_MAX - TIME_W'($urandom_range(0, 3 * period));
      end else if (edge_deadline >= crank_now) begin
         // deadline stuck near the top: an edge at the last time wraps it
         if (lockout_cfg != 0 && edge_deadline > TIME_MAX - NEAR_TOP)
            send_word(OP_EDGE, TIME_MAX);
         crank_now = edge_deadline + TIME_W'($urandom_range(1, 5000));
      end
      t = crank_now;
      for (k = 0; k < n_edges; k++) begin
         t = crank_now;
         send_word(OP_EDGE, t);
         if (lockout_cfg != 0 && $urandom_range(99) < 15)
            send_word(OP_EDGE, t + TIME_W'($urandom_range(1, lockout_cfg)));
         if ($urandom_range(99) < 50) begin
            lag = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, period);
            send_word(OP_QUERY, t + TIME_W'(lag));
         end
         crank_now = t + TIME_W'(period) + TIME_W'($urandom_range(0, period / 8));
      end
      case ($urandom_range(3))
         0: begin
            lag = $urandom_range(0, timeout_cfg - 1);
         end
         1: begin
            lag = timeout_cfg - 1;
         end
         2: begin
            lag = timeout_cfg;
         end
         default: begin
            lag = timeout_cfg + $urandom_range(1, 1000000000);
         end
      endcase
      send_word(OP_QUERY, t + TIME_W'(lag));
   endtask

   task automatic noise_word();
      logic [TIME_W-1:0] t;
      t = TIME_W'({$urandom, $urandom});
      if ($urandom_range(1) == 0 && crank_now != 0) t = t % crank_now;
      send_word(($urandom_range(1) == 1) ? OP_QUERY : OP_EDGE, t);
   endtask

   task automatic test_reset_values();
      send_word(OP_QUERY, '0);
      send_word(OP_EDGE, '0);
      send_word(OP_EDGE, 48'd1);
      send_word(OP_EDGE, 48'd1);
      send_word(OP_QUERY, 48'd1);
   endtask

   task automatic test_lockout_and_depth();
      int k;
      csr_write(CSR_LOCKOUT, 24'd100);
      csr_write(CSR_TIMEOUT, 24'hFFFFFF);
      send_word(OP_EDGE, 48'd1000);
      send_word(OP_EDGE, 48'd1100);
      send_word(OP_EDGE, 48'd1101);
      for (k = 1; k <= 7; k++) send_word(OP_EDGE, 48'd1101 + TIME_W'(200 * k));
      send_word(OP_QUERY, 48'd2501);
   endtask

   task automatic test_timeout_boundary();
      send_word(OP_QUERY, 48'd2501 + 48'hFFFFFE);
      send_word(OP_QUERY, 48'd2501 + 48'hFFFFFF);
      send_word(OP_QUERY, 48'd2501 + 48'hFFFFFF);
   endtask

   task automatic test_time_extremes();
      send_word(OP_EDGE, TIME_MAX - 48'd5);
      send_word(OP_EDGE, TIME_MAX);
      send_word(OP_QUERY, TIME_MAX);
      send_word(OP_EDGE, 48'd40);
      send_word(OP_EDGE, NEAR_TOP);
      send_word(OP_QUERY, NEAR_TOP);
      crank_now = NEAR_TOP + 48'd1000;
   endtask

   task automatic test_random_traffic(input logic [CFG_W-1:0] lockout,
                                      input logic [CFG_W-1:0] timeout, input int n_words);
      int stop_at;
      int r;
      csr_write(CSR_LOCKOUT, lockout);
      csr_write(CSR_TIMEOUT, timeout);
      stop_at = word_total + n_words;
      while (word_total < stop_at) begin
         r = $urandom_range(99);
         if (r < 85) crank_burst();
         else if (r < 98) noise_word();
         else wait_idle();
      end
   endtask

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (interval_q.size() == 0) begin
            report_mismatch("rsp word with nothing expected", rsp_tdata, '0);
         end else begin
            interval_expected = interval_q.pop_front();
            if (rsp_tdata !== interval_expected)
               report_mismatch("interval_us", rsp_tdata, interval_expected);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_lockout_and_depth();
      test_timeout_boundary();
      test_time_extremes();

      test_random_traffic(24'd2000, 24'd3000000, 250);
      test_random_traffic(24'hFFFFFF, 24'd1, 250);

      tx_idle_pct = 60;
      rx_idle_pct = 9;
      test_random_traffic(24'd0, 24'hFFFFFF, 250);
      test_random_traffic(CFG_W'($urandom_range(0, 24'hFFFFFF)),
                          CFG_W'($urandom_range(1, 24'hFFFFFF)), 250);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_traffic(24'd777, 24'd5000, 250);
      test_random_traffic(CFG_W'($urandom_range(0, 100000)),
                          CFG_W'($urandom_range(1000, 24'hFFFFFF)), 250);

      wait_idle();
      if (error_count == 0 && interval_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

endmodule
